### hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, sequencer states and the slot level table shared by the
// sequencer core and the testbench.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Command codes carried in the kind field of a command beat.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  // Slot counts of the units that a command is built from.
  localparam logic [2:0] SLOTS_COND = 3'd3;
  localparam logic [2:0] SLOTS_ZERO = 3'd3;
  localparam logic [2:0] SLOTS_ONE  = 3'd5;
  localparam logic [2:0] SLOTS_ACK  = 3'd2;

  typedef enum logic [3:0] {
    OP_IDLE  = 4'b0001,
    OP_START = 4'b0010,
    OP_WRITE = 4'b0100,
    OP_STOP  = 4'b1000
  } op_t;

  // Line levels driven during one slot, as {scl, sda}.
  // Bit index 8 is the acknowledge phase of a byte.
  function automatic logic [1:0] slot_levels(op_t op, logic [2:0] phase,
                                             logic [3:0] bit_idx,
                                             logic [7:0] data);
    logic       s;
    logic       d;
    logic       cur;
    s   = 1'b1;
    d   = 1'b1;
    cur = data[~bit_idx[2:0]];
    case (op)
      OP_START: begin
        s = (phase < 3'd2);
        d = (phase == 3'd0);
      end
      OP_STOP: begin
        s = (phase >= 3'd1);
        d = (phase == 3'd2);
      end
      OP_WRITE: begin
        if (bit_idx[3]) begin
          s = (phase == 3'd1);
          d = 1'b1;
        end else if (cur) begin
          s = (phase == 3'd2);
          d = (phase >= 3'd1) && (phase <= 3'd3);
        end else begin
          s = (phase == 3'd1);
          d = 1'b0;
        end
      end
      default: begin
        s = 1'b1;
        d = 1'b1;
      end
    endcase
    return {s, d};
  endfunction

endpackage

### hdl/i2cms_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries ticks and commands into the sequencer.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       sda_in;

  modport source (output valid, kind, byte_value, sda_in, input ready);
  modport sink   (input valid, kind, byte_value, sda_in, output ready);
endinterface

### hdl/i2cms_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one line and status result per command beat.
// ----------------------------------------------------------------------------
interface i2cms_res_if;
  logic valid;
  logic ready;
  logic scl_out;
  logic sda_out;
  logic busy_res;
  logic ack_valid;
  logic acked;
  logic rejected;

  modport source (output valid, scl_out, sda_out, busy_res, ack_valid, acked, rejected,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, ack_valid, acked, rejected,
                  output ready);
endinterface

### hdl/i2c_master_bit_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Write-only I2C master that steps SCL and SDA through fixed phase slots.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel takes one beat per tick or command. A tick ends the
//   current slot; start, write byte and stop are taken only while idle, and
//   a command that arrives while busy is dropped and flagged as rejected.
//   Every cmd beat yields exactly one res beat with the line levels after
//   that beat, the busy flag and, at the end of a byte, the acknowledge.
//   The result of an accepted beat is registered and offered on res in the
//   next cycle. Throughput is one beat per cycle while res is not stalled;
//   the sequencer state and the result register update in the same cycle
//   through one short slot decode, so nothing else limits the rate.
//   The result register parts the two sides: cmd stays ready while res is
//   empty or being taken. When the receiver stalls, the held result waits
//   and cmd.ready drops until it is taken.
//   After reset the sequencer is idle with SCL and SDA released high and
//   the result register is empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core (
  input  logic         clk,
  input  logic         rst,
  i2cms_cmd_if.sink    cmd,
  i2cms_res_if.source  res
);

  i2cms_pkg::op_t operation, operation_next;
  logic [2:0] phase_slot, phase_slot_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;

  logic       ack_valid_next;
  logic       acked_next;
  logic       rejected_next;
  logic       apply;
  logic       accept;
  logic       res_valid;
  logic [2:0] unit_slots;
  logic [3:0] phase_inc;
  i2cms_pkg::op_t cmd_op;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign res.valid = res_valid;

  always_comb begin
    case (cmd.kind)
      i2cms_pkg::KIND_START: cmd_op = i2cms_pkg::OP_START;
      i2cms_pkg::KIND_WRITE: cmd_op = i2cms_pkg::OP_WRITE;
      i2cms_pkg::KIND_STOP:  cmd_op = i2cms_pkg::OP_STOP;
      default:               cmd_op = i2cms_pkg::OP_IDLE;
    endcase
  end

  // A one bit stretches to five slots so SDA can rise and fall around SCL.
  always_comb begin
    if (operation == i2cms_pkg::OP_WRITE) begin
      if (bit_index[3]) begin
        unit_slots = i2cms_pkg::SLOTS_ACK;
      end else if (shift_byte[~bit_index[2:0]]) begin
        unit_slots = i2cms_pkg::SLOTS_ONE;
      end else begin
        unit_slots = i2cms_pkg::SLOTS_ZERO;
      end
    end else begin
      unit_slots = i2cms_pkg::SLOTS_COND;
    end
  end

  assign phase_inc = {1'b0, phase_slot} + 4'd1;

  always_comb begin
    operation_next  = operation;
    phase_slot_next = phase_slot;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_valid_next  = 1'b0;
    acked_next      = 1'b0;
    rejected_next   = 1'b0;
    apply           = 1'b0;
    if (cmd.kind != i2cms_pkg::KIND_TICK) begin
      if (operation != i2cms_pkg::OP_IDLE) begin
        rejected_next = 1'b1;
      end else begin
        operation_next  = cmd_op;
        phase_slot_next = 3'd0;
        bit_index_next  = 4'd0;
        if (cmd.kind == i2cms_pkg::KIND_WRITE) begin
          shift_byte_next = cmd.byte_value;
        end
        apply = 1'b1;
      end
    end else if (operation != i2cms_pkg::OP_IDLE) begin
      if (phase_inc < {1'b0, unit_slots}) begin
        phase_slot_next = phase_inc[2:0];
        apply           = 1'b1;
      end else if (operation == i2cms_pkg::OP_WRITE) begin
        if (bit_index[3]) begin
          // End of the ack phase: a low SDA from the slave is the acknowledge.
          ack_valid_next  = 1'b1;
          acked_next      = !cmd.sda_in;
          scl_level_next  = 1'b0;
          sda_level_next  = 1'b0;
          operation_next  = i2cms_pkg::OP_IDLE;
          phase_slot_next = 3'd0;
          bit_index_next  = 4'd0;
        end else begin
          bit_index_next  = bit_index + 4'd1;
          phase_slot_next = 3'd0;
          apply           = 1'b1;
        end
      end else begin
        // A finished condition keeps the levels of its last slot.
        operation_next  = i2cms_pkg::OP_IDLE;
        phase_slot_next = 3'd0;
      end
    end
    if (apply) begin
      {scl_level_next, sda_level_next} = i2cms_pkg::slot_levels(
          operation_next, phase_slot_next, bit_index_next, shift_byte_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= i2cms_pkg::OP_IDLE;
      phase_slot <= 3'd0;
      bit_index  <= 4'd0;
      shift_byte <= 8'd0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
    end else if (accept) begin
      operation  <= operation_next;
      phase_slot <= phase_slot_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl_out   <= scl_level_next;
      res.sda_out   <= sda_level_next;
      res.busy_res  <= (operation_next != i2cms_pkg::OP_IDLE);
      res.ack_valid <= ack_valid_next;
      res.acked     <= acked_next;
      res.rejected  <= rejected_next;
    end
  end

  // A rejected command never changes the state, so the sequencer stays busy.
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rejected |-> res.busy_res)
    else $error("rejected result without busy");

  // The end of a byte leaves the bus idle with both lines driven low.
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ack_valid |-> !res.busy_res && !res.scl_out && !res.sda_out)
    else $error("ack result with wrong bus state");

  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.acked |-> res.ack_valid)
    else $error("acked without ack_valid");

  assert property (@(posedge clk) disable iff (rst)
    operation == i2cms_pkg::OP_IDLE |-> phase_slot == 3'd0 && bit_index == 4'd0)
    else $error("idle sequencer with stale slot counters");

  assert property (@(posedge clk) disable iff (rst)
    bit_index[3] |-> operation == i2cms_pkg::OP_WRITE && bit_index[2:0] == 3'd0
                     && phase_slot < i2cms_pkg::SLOTS_ACK)
    else $error("ack phase out of range");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> res.valid)
    else $error("accepted beat produced no result");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives ticks and start, write byte and stop commands into the sequencer and
// checks every result beat against a line level predictor kept in the bench
// or a fixed row result. A short table of directed beats comes first, then
// transaction-shaped random traffic with noise commands, random gaps on both
// sides and one long stall of the result receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_BEATS = 480;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 64;
  localparam int DRAIN_LIMIT  = 2000;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic ack_valid;
    logic acked;
    logic rejected;
  } line_res_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] byte_v;
    logic       sda;
    bit         fixed;
    line_res_t  res;
  } stim_row_t;

  logic clk;
  logic rst;

  i2cms_cmd_if cmd_ch ();
  i2cms_res_if res_ch ();

  i2c_master_bit_sequencer_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Predicted sequencer state.
  i2cms_pkg::op_t cur_op  = i2cms_pkg::OP_IDLE;
  logic [2:0]     slot    = 3'd0;
  logic [3:0]     bit_pos = 4'd0;
  logic [7:0]     shifter = 8'd0;
  logic           scl_lvl = 1'b1;
  logic           sda_lvl = 1'b1;

  line_res_t  pending_levels[$];
  stim_row_t  directed_rows[$];
  int         fail_cnt = 0;

  // Transaction plan for the random part.
  int         txn_stage   = 0;
  int         writes_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic cur_data_bit();
    return shifter[3'd7 - bit_pos[2:0]];
  endfunction

  function automatic logic [2:0] unit_len();
    if (cur_op == i2cms_pkg::OP_WRITE) begin
      if (bit_pos[3]) return i2cms_pkg::SLOTS_ACK;
      return cur_data_bit() ? i2cms_pkg::SLOTS_ONE : i2cms_pkg::SLOTS_ZERO;
    end
    return i2cms_pkg::SLOTS_COND;
  endfunction

  function automatic void set_levels();
    case (cur_op)
      i2cms_pkg::OP_START: begin
        scl_lvl = (slot < 3'd2);
        sda_lvl = (slot == 3'd0);
      end
      i2cms_pkg::OP_STOP: begin
        scl_lvl = (slot >= 3'd1);
        sda_lvl = (slot == 3'd2);
      end
      i2cms_pkg::OP_WRITE: begin
        if (bit_pos[3]) begin
          scl_lvl = (slot == 3'd1);
          sda_lvl = 1'b1;
        end else if (cur_data_bit()) begin
          scl_lvl = (slot == 3'd2);
          sda_lvl = (slot >= 3'd1) && (slot <= 3'd3);
        end else begin
          scl_lvl = (slot == 3'd1);
          sda_lvl = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the predicted sequencer by one beat and returns the line result.
  function automatic line_res_t line_step(logic [1:0] k, logic [7:0] b, logic s);
    line_res_t  r;
    logic [2:0] nxt;
    r = '0;
    if (k != i2cms_pkg::KIND_TICK) begin
      if (cur_op != i2cms_pkg::OP_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        case (k)
          i2cms_pkg::KIND_START: cur_op = i2cms_pkg::OP_START;
          i2cms_pkg::KIND_WRITE: cur_op = i2cms_pkg::OP_WRITE;
          default:               cur_op = i2cms_pkg::OP_STOP;
        endcase
        slot    = 3'd0;
        bit_pos = 4'd0;
        if (k == i2cms_pkg::KIND_WRITE) shifter = b;
        set_levels();
      end
    end else if (cur_op != i2cms_pkg::OP_IDLE) begin
      nxt = slot + 3'd1;
      if (nxt < unit_len()) begin
        slot = nxt;
        set_levels();
      end else if (cur_op == i2cms_pkg::OP_WRITE) begin
        if (bit_pos[3]) begin
          // The tick that closes the ack slot samples the line.
          r.ack_valid = 1'b1;
          r.acked     = ~s;
          scl_lvl     = 1'b0;
          sda_lvl     = 1'b0;
          cur_op      = i2cms_pkg::OP_IDLE;
          slot        = 3'd0;
          bit_pos     = 4'd0;
        end else begin
          bit_pos = bit_pos + 4'd1;
          slot    = 3'd0;
          set_levels();
        end
      end else begin
        // A finished condition keeps the levels of its last slot.
        cur_op = i2cms_pkg::OP_IDLE;
        slot   = 3'd0;
      end
    end
    r.scl  = scl_lvl;
    r.sda  = sda_lvl;
    r.busy = (cur_op != i2cms_pkg::OP_IDLE);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] k, logic [7:0] b, logic s, bit fixed,
                                  line_res_t res);
    stim_row_t row;
    row.kind   = k;
    row.byte_v = b;
    row.sda    = s;
    row.fixed  = fixed;
    row.res    = res;
    directed_rows.push_back(row);
  endfunction

  // Picks the next random beat from the predicted state: mostly well-formed
  // start, write, stop transactions, with stray ticks and commands mixed in.
  function automatic stim_row_t pick_beat();
    stim_row_t row;
    int        r;
    r          = $urandom_range(99);
    row.kind   = i2cms_pkg::KIND_TICK;
    row.byte_v = 8'($urandom);
    row.sda    = 1'($urandom);
    row.fixed  = 1'b0;
    row.res    = '0;
    if (cur_op != i2cms_pkg::OP_IDLE) begin
      if (r < 6) row.kind = 2'($urandom_range(1, 3));
    end else if (r < 8) begin
      row.kind = i2cms_pkg::KIND_TICK;
    end else if (r < 12) begin
      row.kind = 2'($urandom_range(1, 3));
    end else begin
      case (txn_stage)
        0: begin
          row.kind    = i2cms_pkg::KIND_START;
          writes_left = $urandom_range(1, 3);
          txn_stage   = 1;
        end
        1: begin
          row.kind    = i2cms_pkg::KIND_WRITE;
          writes_left = writes_left - 1;
          if (writes_left == 0) txn_stage = 2;
        end
        default: begin
          row.kind  = i2cms_pkg::KIND_STOP;
          txn_stage = 0;
        end
      endcase
    end
    return row;
  endfunction

  task automatic send_beat(stim_row_t row);
    line_res_t r;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= row.kind;
    cmd_ch.byte_value <= row.byte_v;
    cmd_ch.sda_in     <= row.sda;
    do @(posedge clk); while (!cmd_ch.ready);
    r = line_step(row.kind, row.byte_v, row.sda);
    pending_levels.push_back(row.fixed ? row.res : r);
  endtask

  task automatic maybe_pause(bit quiet);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 11) gap = 1;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Command sender.
  initial begin
    int        waited;
    stim_row_t row;
    cmd_ch.valid      = 1'b0;
    cmd_ch.kind       = i2cms_pkg::KIND_TICK;
    cmd_ch.byte_value = 8'd0;
    cmd_ch.sda_in     = 1'b1;

    // Directed beats; fixed rows are {scl, sda, busy, ack_valid, acked, rejected}.
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b1,
            '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(i2cms_pkg::KIND_START, 8'hFF, 1'b1, 1'b0, '0);
    add_row(i2cms_pkg::KIND_WRITE, 8'hA5, 1'b0, 1'b1,
            '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b1, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'hFF, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b1, 1'b1,
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(i2cms_pkg::KIND_STOP,  8'h00, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_STOP,  8'hFF, 1'b1, 1'b1,
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b1, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b1,
            '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(i2cms_pkg::KIND_TICK,  8'hFF, 1'b0, 1'b1,
            '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(i2cms_pkg::KIND_START, 8'h00, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_WRITE, 8'hFF, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_START, 8'h00, 1'b1, 1'b1,
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b1, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'hFF, 1'b0, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b1, 1'b0, '0);
    add_row(i2cms_pkg::KIND_TICK,  8'h00, 1'b0, 1'b0, '0);

    do @(posedge clk); while (rst);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i]);
      maybe_pause(1'b0);
    end

    // The write byte left open above is finished by the random beats.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      row = pick_beat();
      send_beat(row);
      maybe_pause(n >= 200 && n < 350);
    end
    cmd_ch.valid <= 1'b0;

    waited = 0;
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_levels.size() != 0) begin
      $error("%0d result beats never arrived", pending_levels.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result receiver with random stalls, a quiet stretch and one long hold-off
  // that backs the sequencer up into its command channel.
  initial begin
    int cyc;
    cyc          = 0;
    res_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_AT) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (cyc >= 100 && cyc < 250) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 11);
      end
    end
  end

  line_res_t want;

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_cnt++;
      end else begin
        want = pending_levels.pop_front();
        if (res_ch.scl_out !== want.scl) begin
          $error("scl_out: expected %b, got %b", want.scl, res_ch.scl_out);
          fail_cnt++;
        end
        if (res_ch.sda_out !== want.sda) begin
          $error("sda_out: expected %b, got %b", want.sda, res_ch.sda_out);
          fail_cnt++;
        end
        if (res_ch.busy_res !== want.busy) begin
          $error("busy_res: expected %b, got %b", want.busy, res_ch.busy_res);
          fail_cnt++;
        end
        if (res_ch.ack_valid !== want.ack_valid) begin
          $error("ack_valid: expected %b, got %b", want.ack_valid, res_ch.ack_valid);
          fail_cnt++;
        end
        if (res_ch.acked !== want.acked) begin
          $error("acked: expected %b, got %b", want.acked, res_ch.acked);
          fail_cnt++;
        end
        if (res_ch.rejected !== want.rejected) begin
          $error("rejected: expected %b, got %b", want.rejected, res_ch.rejected);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
